// ===== rtl/hpp_pkg.sv =====
`timescale 1ns / 1ps
package hpp_pkg;

   localparam int PIX_W  = 16;
   localparam int COEF_W = 32;
   localparam int THR_W  = 31;
   localparam int PROD_W = COEF_W + PIX_W + 1;
   localparam int SUM_W  = 50;
   localparam int MAG_W  = 50;
   localparam int Q_W    = 48;
   localparam int FRAC_W = 16;
   localparam int INT_W  = 32;
   localparam int CSR_W  = 64;
   localparam int CSR_A  = 3;
   localparam int REQ_W  = 32;
   localparam int RSP_W  = 96;
   localparam int USER_W = 2;

   localparam logic [CSR_A-1:0] CSR_H11_H12 = 3'd0;
   localparam logic [CSR_A-1:0] CSR_H13_H21 = 3'd1;
   localparam logic [CSR_A-1:0] CSR_H22_H23 = 3'd2;
   localparam logic [CSR_A-1:0] CSR_H31_H32 = 3'd3;
   localparam logic [CSR_A-1:0] CSR_H33     = 3'd4;
   localparam logic [CSR_A-1:0] CSR_W_THR   = 3'd5;

   typedef struct packed {
      logic signed [COEF_W-1:0] h11;
      logic signed [COEF_W-1:0] h12;
      logic signed [COEF_W-1:0] h13;
      logic signed [COEF_W-1:0] h21;
      logic signed [COEF_W-1:0] h22;
      logic signed [COEF_W-1:0] h23;
      logic signed [COEF_W-1:0] h31;
      logic signed [COEF_W-1:0] h32;
      logic signed [COEF_W-1:0] h33;
      logic [THR_W-1:0]         thr;
   } coef_type;

   typedef struct packed {
      logic [MAG_W-1:0] ax;
      logic [MAG_W-1:0] ay;
      logic [MAG_W-1:0] aw;
      logic             neg_x;
      logic             neg_y;
      logic             invalid;
      logic             ov_x;
      logic             ov_y;
   } div_item_type;

endpackage

// ===== rtl/homography_point_to_plane_core.sv =====
`timescale 1ns / 1ps
// Pixel to ground plane mapping through a 3x3 homography.
// req_ channel: one pixel coordinate per item (Q12.4 x and y).
// rsp_ channel: one result per item, world x/y in Q32.16 in tdata, valid and
// saturated flags in tuser; invalid (small |w|) results carry zero coordinates.
// csr_ port: write coefficients and w threshold while no item is in flight.
// Throughput: one item per cycle while rsp_tready stays high.
// Path from req to rsp: input register and 3 front stages (multiply, sum,
// classify), one queue slot, 49 divider stages (entry stage, then one
// quotient bit per stage for 48 bits) and the output register.
// Reset clears all valid state and loads the identity homography with
// threshold 1; no clearing pass.
// When rsp_tready is low the back pipeline holds, the queue fills, then
// the front pipeline holds and req_tready drops. Nothing is dropped.
module homography_point_to_plane_core
   import hpp_pkg::*;
#(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_we,
   input  logic [CSR_A-1:0]   csr_addr,
   input  logic [CSR_W-1:0]   csr_wdata,
   input  logic               req_tvalid,
   output logic               req_tready,
   input  logic [REQ_W-1:0]   req_tdata,   // pixel_x, pixel_y
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output logic [RSP_W-1:0]   rsp_tdata,   // world_x, world_y
   output logic [USER_W-1:0]  rsp_tuser    // valid_res, saturated
);

   coef_type coef_ff;
   logic push, push_ok, pop, q_empty, q_full;
   div_item_type push_item, q_head;

   always_ff @(posedge clock) begin
      if (reset) begin
         coef_ff.h11 <= 32'sd65536;
         coef_ff.h12 <= '0;
         coef_ff.h13 <= '0;
         coef_ff.h21 <= '0;
         coef_ff.h22 <= 32'sd65536;
         coef_ff.h23 <= '0;
         coef_ff.h31 <= '0;
         coef_ff.h32 <= '0;
         coef_ff.h33 <= 32'sd65536;
         coef_ff.thr <= 31'd1;
      end else if (csr_we) begin
         unique case (csr_addr)
            CSR_H11_H12: begin
               coef_ff.h11 <= csr_wdata[63:32];
               coef_ff.h12 <= csr_wdata[31:0];
            end
            CSR_H13_H21: begin
               coef_ff.h13 <= csr_wdata[63:32];
               coef_ff.h21 <= csr_wdata[31:0];
            end
            CSR_H22_H23: begin
               coef_ff.h22 <= csr_wdata[63:32];
               coef_ff.h23 <= csr_wdata[31:0];
            end
            CSR_H31_H32: begin
               coef_ff.h31 <= csr_wdata[63:32];
               coef_ff.h32 <= csr_wdata[31:0];
            end
            CSR_H33:   coef_ff.h33 <= csr_wdata[31:0];
            CSR_W_THR: coef_ff.thr <= csr_wdata[30:0];
            default: ;
         endcase
      end
   end

   assign push_ok = !q_full || pop;

   hpp_front u_front (
      .clock     (clock),
      .reset     (reset),
      .coef      (coef_ff),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_px     (req_tdata[15:0]),
      .in_py     (req_tdata[31:16]),
      .push      (push),
      .push_item (push_item),
      .push_ok   (push_ok)
   );

   hpp_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop       (pop),
      .head      (q_head),
      .empty     (q_empty),
      .full      (q_full)
   );

   hpp_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_empty   (q_empty),
      .q_head    (q_head),
      .pop       (pop),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (rsp_tdata),
      .out_user  (rsp_tuser)
   );

endmodule

// ===== rtl/hpp_front.sv =====
`timescale 1ns / 1ps
module hpp_front
   import hpp_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  coef_type           coef,
   input  logic               in_valid,
   output logic               in_ready,
   input  logic [PIX_W-1:0]   in_px,
   input  logic [PIX_W-1:0]   in_py,
   output logic               push,
   output div_item_type       push_item,
   input  logic               push_ok
);

   logic v1_ff, v2_ff, v3_ff, v4_ff;
   logic en;
   logic [PIX_W-1:0] px1_ff, py1_ff;
   logic signed [PROD_W-1:0] p_in [6];
   logic signed [PROD_W-1:0] p_ff [6];
   logic signed [SUM_W-1:0] x_in, y_in, w_in;
   logic signed [SUM_W-1:0] x_ff, y_ff, w_ff;
   div_item_type item_in, item_ff;
   logic [MAG_W-1:0] ax, ay, aw;

   assign en       = !v4_ff || push_ok;
   assign in_ready = en;
   assign push     = v4_ff && push_ok;
   assign push_item = item_ff;

   always_comb begin
      p_in[0] = coef.h11 * $signed({1'b0, px1_ff});
      p_in[1] = coef.h12 * $signed({1'b0, py1_ff});
      p_in[2] = coef.h21 * $signed({1'b0, px1_ff});
      p_in[3] = coef.h22 * $signed({1'b0, py1_ff});
      p_in[4] = coef.h31 * $signed({1'b0, px1_ff});
      p_in[5] = coef.h32 * $signed({1'b0, py1_ff});
   end

   // constant column enters as 1.0 in Q12.4
   assign x_in = SUM_W'(p_ff[0]) + SUM_W'(p_ff[1]) + SUM_W'($signed({coef.h13, 4'b0}));
   assign y_in = SUM_W'(p_ff[2]) + SUM_W'(p_ff[3]) + SUM_W'($signed({coef.h23, 4'b0}));
   assign w_in = SUM_W'(p_ff[4]) + SUM_W'(p_ff[5]) + SUM_W'($signed({coef.h33, 4'b0}));

   always_comb begin
      ax = x_ff[SUM_W-1] ? MAG_W'(-x_ff) : MAG_W'(x_ff);
      ay = y_ff[SUM_W-1] ? MAG_W'(-y_ff) : MAG_W'(y_ff);
      aw = w_ff[SUM_W-1] ? MAG_W'(-w_ff) : MAG_W'(w_ff);
      item_in.ax      = ax;
      item_in.ay      = ay;
      item_in.aw      = aw;
      item_in.neg_x   = x_ff[SUM_W-1] ^ w_ff[SUM_W-1];
      item_in.neg_y   = y_ff[SUM_W-1] ^ w_ff[SUM_W-1];
      item_in.invalid = (aw == '0) || (aw < MAG_W'(coef.thr));
      item_in.ov_x    = MAG_W'(ax[MAG_W-1:INT_W]) >= aw;
      item_in.ov_y    = MAG_W'(ay[MAG_W-1:INT_W]) >= aw;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         px1_ff  <= in_px;
         py1_ff  <= in_py;
         p_ff    <= p_in;
         x_ff    <= x_in;
         y_ff    <= y_in;
         w_ff    <= w_in;
         item_ff <= item_in;
      end
   end

endmodule

// ===== rtl/hpp_queue.sv =====
`timescale 1ns / 1ps
module hpp_queue
   import hpp_pkg::*;
#(
   parameter int DEPTH = 4
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  div_item_type push_item,
   input  logic         pop,
   output div_item_type head,
   output logic         empty,
   output logic         full
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   div_item_type mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ff, rd_ff;
   logic [CNT_W-1:0] cnt_ff;

   assign empty = (cnt_ff == '0);
   assign full  = (cnt_ff == CNT_W'(DEPTH));
   assign head  = mem_ff[rd_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         if (push) begin
            wr_ff <= (wr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ff + 1'b1;
         end
         if (pop) begin
            rd_ff <= (rd_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ff + 1'b1;
         end
         if (push && !pop) begin
            cnt_ff <= cnt_ff + 1'b1;
         end else if (pop && !push) begin
            cnt_ff <= cnt_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ff] <= push_item;
      end
   end

endmodule

// ===== rtl/hpp_back.sv =====
`timescale 1ns / 1ps
module hpp_back
   import hpp_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              q_empty,
   input  div_item_type      q_head,
   output logic              pop,
   output logic              out_valid,
   input  logic              out_ready,
   output logic [RSP_W-1:0]  out_data,
   output logic [USER_W-1:0] out_user
);

   typedef struct packed {
      logic [MAG_W-1:0] r;
      logic [Q_W-1:0]   q;
      logic [MAG_W-1:0] an;
   } lane_type;

   typedef struct packed {
      logic             valid;
      lane_type         x;
      lane_type         y;
      logic [MAG_W-1:0] ad;
      logic             neg_x;
      logic             neg_y;
      logic             invalid;
      logic             ov_x;
      logic             ov_y;
   } stage_type;

   function automatic lane_type step_lane(lane_type l, logic [MAG_W-1:0] ad, logic nbit);
      logic [MAG_W+1:0] sh;
      logic [MAG_W+1:0] diff;
      logic             ge;
      lane_type         o;
      sh   = {1'b0, l.r, nbit};
      diff = sh - {2'b0, ad};
      ge   = !diff[MAG_W+1];
      o.r  = ge ? diff[MAG_W-1:0] : sh[MAG_W-1:0];
      o.q  = {l.q[Q_W-2:0], ge};
      o.an = l.an;
      return o;
   endfunction

   function automatic logic [Q_W:0] finish(logic [Q_W-1:0] mag, logic neg, logic ov);
      logic             sat;
      logic [Q_W-1:0]   val;
      if (!neg) begin
         sat = ov || mag[Q_W-1];
         val = sat ? {1'b0, {(Q_W-1){1'b1}}} : mag;
      end else begin
         sat = ov || (mag[Q_W-1] && (|mag[Q_W-2:0]));
         val = sat ? {1'b1, {(Q_W-1){1'b0}}} : -mag;
      end
      return {sat, val};
   endfunction

   stage_type st_ff [Q_W+1];
   stage_type st_in [Q_W+1];
   logic en;
   logic out_valid_ff;
   logic [RSP_W-1:0] out_data_ff, out_data_in;
   logic [USER_W-1:0] out_user_ff, out_user_in;
   logic [Q_W:0] fx, fy;

   assign en        = !out_valid_ff || out_ready;
   assign pop       = en && !q_empty;
   assign out_valid = out_valid_ff;
   assign out_data  = out_data_ff;
   assign out_user  = out_user_ff;

   always_comb begin
      st_in[0].valid   = !q_empty;
      st_in[0].x.r     = MAG_W'(q_head.ax[MAG_W-1:INT_W]);
      st_in[0].x.q     = '0;
      st_in[0].x.an    = q_head.ax;
      st_in[0].y.r     = MAG_W'(q_head.ay[MAG_W-1:INT_W]);
      st_in[0].y.q     = '0;
      st_in[0].y.an    = q_head.ay;
      st_in[0].ad      = q_head.aw;
      st_in[0].neg_x   = q_head.neg_x;
      st_in[0].neg_y   = q_head.neg_y;
      st_in[0].invalid = q_head.invalid;
      st_in[0].ov_x    = q_head.ov_x;
      st_in[0].ov_y    = q_head.ov_y;
   end

   // stage k settles quotient bit Q_W-1-k; dividend is |num| << 16
   for (genvar k = 0; k < Q_W; k++) begin : g_div
      localparam int BIT = Q_W - 1 - k;
      logic nbx, nby;
      if (BIT >= FRAC_W) begin : g_hi
         assign nbx = st_ff[k].x.an[BIT-FRAC_W];
         assign nby = st_ff[k].y.an[BIT-FRAC_W];
      end else begin : g_lo
         assign nbx = 1'b0;
         assign nby = 1'b0;
      end
      always_comb begin
         st_in[k+1]   = st_ff[k];
         st_in[k+1].x = step_lane(st_ff[k].x, st_ff[k].ad, nbx);
         st_in[k+1].y = step_lane(st_ff[k].y, st_ff[k].ad, nby);
      end
   end

   always_comb begin
      fx = finish(st_ff[Q_W].x.q, st_ff[Q_W].neg_x, st_ff[Q_W].ov_x);
      fy = finish(st_ff[Q_W].y.q, st_ff[Q_W].neg_y, st_ff[Q_W].ov_y);
      out_data_in = '0;
      out_user_in = '0;
      if (!st_ff[Q_W].invalid) begin
         out_data_in[Q_W-1:0]     = fx[Q_W-1:0];
         out_data_in[2*Q_W-1:Q_W] = fy[Q_W-1:0];
         out_user_in[0]           = 1'b1;
         out_user_in[1]           = fx[Q_W] | fy[Q_W];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i <= Q_W; i++) begin
            st_ff[i].valid <= 1'b0;
         end
         out_valid_ff <= 1'b0;
      end else if (en) begin
         for (int i = 0; i <= Q_W; i++) begin
            st_ff[i].valid <= st_in[i].valid;
         end
         out_valid_ff <= st_ff[Q_W].valid;
      end
      if (en) begin
         for (int i = 0; i <= Q_W; i++) begin
            st_ff[i].x       <= st_in[i].x;
            st_ff[i].y       <= st_in[i].y;
            st_ff[i].ad      <= st_in[i].ad;
            st_ff[i].neg_x   <= st_in[i].neg_x;
            st_ff[i].neg_y   <= st_in[i].neg_y;
            st_ff[i].invalid <= st_in[i].invalid;
            st_ff[i].ov_x    <= st_in[i].ov_x;
            st_ff[i].ov_y    <= st_in[i].ov_y;
         end
         out_data_ff <= out_data_in;
         out_user_ff <= out_user_in;
      end
   end

endmodule

// ===== rtl/hpp_checker.sv =====
`timescale 1ns / 1ps
module hpp_checker
   import hpp_pkg::*;
(
   input logic               clock,
   input logic               reset,
   input logic               rsp_tvalid,
   input logic               rsp_tready,
   input logic [RSP_W-1:0]   rsp_tdata,
   input logic [USER_W-1:0]  rsp_tuser
);

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("rsp item changed while stalled");

   a_invalid_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[0] |-> rsp_tdata == '0 && !rsp_tuser[1])
      else $error("invalid item carries data");

   a_sat_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[1] |-> rsp_tuser[0])
      else $error("saturated without valid_res");

   a_reset_idle: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("rsp valid right after reset");

endmodule

bind homography_point_to_plane_core hpp_checker u_hpp_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
